// File: hw/rtl/tsn_pkg.sv
// tsn_pkg: shared constants, field layout, codes and types of the texture sampler
// depends on nothing; imported by tsn_blend and texture_sampler_nearest_bilinear
package tsn_pkg;

    // texel store
    localparam int MAX_TEXELS = 4096;
    localparam int TEX_ADDR_W = $clog2(MAX_TEXELS);
    localparam int LIMIT_W    = TEX_ADDR_W + 1;

    // field widths
    localparam int CHAN_W    = 16;
    localparam int TEXEL_W   = 4 * CHAN_W;
    localparam int SIZE_W    = 7;
    localparam int COORD_W   = 18;
    localparam int FRAC_W    = 16;
    localparam int INDEX_W   = 12;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    // internal arithmetic widths
    localparam int POS_W  = COORD_W + SIZE_W;  // u*W in Q.16, signed
    localparam int CELL_W = POS_W - FRAC_W;    // integer texel coordinate, signed
    localparam int IDX_W  = 16;                // signed flat index
    localparam int WGT_W  = FRAC_W + 1;        // weight 0..65536
    localparam int HSUM_W = 32;                // horizontal blend sum
    localparam int ACC_W  = 48;                // full blend sum

    // input tdata layout, lowest bit first
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_RGBA_LSB  = IN_IDX_LSB + INDEX_W;
    localparam int IN_U_LSB     = IN_RGBA_LSB + TEXEL_W;
    localparam int IN_V_LSB     = IN_U_LSB + COORD_W;
    localparam int IN_DATA_BITS = IN_V_LSB + COORD_W;
    localparam int IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;

    // fixed-point constants
    localparam logic [WGT_W-1:0] ONE_Q16  = WGT_W'(65536);
    localparam logic [POS_W-1:0] HALF_Q16 = POS_W'(32768);
    localparam logic [ACC_W-1:0] ROUND_32 = ACC_W'(64'h8000_0000);
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(64);

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEAREST  = 2'd1;
    localparam logic [OP_W-1:0] OP_BILINEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;

    // control from the sequencer to the blend lanes
    typedef struct packed {
        logic       tex_en;    // texel read data is valid this cycle
        logic [1:0] tex_sel;   // which neighbor: bit0 right column, bit1 lower row
        logic       v_first;   // start vertical blend with the upper row
        logic       v_second;  // add in the lower row
    } blend_ctrl_t;

    // a size of 0 acts as 1, above 64 acts as 64
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] s;
        s = r;
        if (r == '0) begin
            s = SIZE_W'(1);
        end
        else if (r > MAX_SIZE) begin
            s = MAX_SIZE;
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/tsn_ram.sv
// tsn_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module tsn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tsn_blend.sv
// tsn_blend: four channel lanes of the bilinear blend, horizontal then vertical
// depends on tsn_pkg
module tsn_blend
    import tsn_pkg::*;
(
    input  logic               clk,
    input  blend_ctrl_t        ctrl,
    input  logic [FRAC_W-1:0]  fu,
    input  logic [FRAC_W-1:0]  fv,
    input  logic [TEXEL_W-1:0] texel,
    output logic [TEXEL_W-1:0] color
);

    logic [HSUM_W-1:0] hacc_reg [4];
    logic [HSUM_W-1:0] hacc_next [4];
    logic [HSUM_W-1:0] htop_reg [4];
    logic [HSUM_W-1:0] htop_next [4];
    logic [ACC_W-1:0]  acc_reg [4];
    logic [ACC_W-1:0]  acc_next [4];

    logic [WGT_W-1:0]  wu;
    logic [WGT_W-1:0]  wv_top;
    logic [WGT_W+CHAN_W-1:0] hprod [4];
    logic [HSUM_W-1:0] hsum [4];
    logic [HSUM_W+WGT_W-1:0] vprod_top [4];
    logic [HSUM_W+FRAC_W-1:0] vprod_bot [4];
    logic [ACC_W-1:0]  rounded [4];

    // left column weighs 1-fu, right column fu
    assign wu     = ctrl.tex_sel[0] ? {1'b0, fu} : (ONE_Q16 - {1'b0, fu});
    assign wv_top = ONE_Q16 - {1'b0, fv};

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            hprod[c]     = texel[c*CHAN_W +: CHAN_W] * wu;
            hsum[c]      = hacc_reg[c] + hprod[c][HSUM_W-1:0];
            vprod_top[c] = htop_reg[c] * wv_top;
            vprod_bot[c] = hacc_reg[c] * fv;
            rounded[c]   = acc_reg[c] + ROUND_32;
            color[c*CHAN_W +: CHAN_W] = rounded[c][ACC_W-1 -: CHAN_W];

            hacc_next[c] = hacc_reg[c];
            htop_next[c] = htop_reg[c];
            acc_next[c]  = acc_reg[c];
            if (ctrl.tex_en)
            begin
                if (!ctrl.tex_sel[0])
                begin
                    hacc_next[c] = hprod[c][HSUM_W-1:0];
                end
                else if (!ctrl.tex_sel[1])
                begin
                    htop_next[c] = hsum[c];
                end
                else
                begin
                    // lower row sum stays in the running register
                    hacc_next[c] = hsum[c];
                end
            end
            if (ctrl.v_first)
            begin
                acc_next[c] = vprod_top[c][ACC_W-1:0];
            end
            else if (ctrl.v_second)
            begin
                acc_next[c] = acc_reg[c] + vprod_bot[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            hacc_reg[c] <= hacc_next[c];
            htop_reg[c] <= htop_next[c];
            acc_reg[c]  <= acc_next[c];
        end
    end

endmodule

// File: hw/rtl/texture_sampler_nearest_bilinear.sv
// texture_sampler_nearest_bilinear: top level, texel store, coordinate sequencer, output register
// depends on tsn_pkg, tsn_ram, tsn_blend
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------------------
//  s_axis   | in        | op in tuser; index, rgba, u, v in tdata
//  m_axis   | out       | rgba in tdata; out_of_bounds in tuser; one per sample only
//  cfg      | in        | cfg_we with cfg_index / cfg_wdata: texture width, height
//
//  a texel write goes to the store on accept; the block stays ready
//  nearest sample: one texel read; bilinear: the four texels are read one by one
//  through the single read port of the store; a new sample is accepted only when idle
//  out-of-bounds bilinear sample skips the reads
//  reset clears control and the size registers (64 x 64); the store is not cleared
//  a result waits in the output register; the engine parks at its end only while
//  that register is still full and not being taken
module texture_sampler_nearest_bilinear
    import tsn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: texel_index, in_red, in_green, in_blue, in_alpha, u_coord, v_coord
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op
    input  logic [OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_red, out_green, out_blue, out_alpha
    output logic [TEXEL_W-1:0]    m_axis_tdata,
    // tuser: out_of_bounds
    output logic                  m_axis_tuser,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_wdata
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COORD = 3'd1;
    localparam logic [2:0] S_INDEX = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_VMUL0 = 3'd5;
    localparam logic [2:0] S_VMUL1 = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic [SIZE_W-1:0] w_eff, h_eff;

    // input fields
    logic [OP_W-1:0]           in_op;
    logic [INDEX_W-1:0]        in_index;
    logic [TEXEL_W-1:0]        in_rgba;
    logic signed [COORD_W-1:0] in_u, in_v;

    // sample context
    logic                      bil_reg, bil_next;
    logic signed [COORD_W-1:0] u_reg, u_next;
    logic signed [COORD_W-1:0] v_reg, v_next;
    logic signed [POS_W-1:0]   pu_reg, pu_next;
    logic signed [POS_W-1:0]   pv_reg, pv_next;
    logic [LIMIT_W-1:0]        limit_reg, limit_next;
    logic signed [CELL_W-1:0]  x_reg, x_next;
    logic signed [CELL_W-1:0]  y_reg, y_next;
    logic [FRAC_W-1:0]         fu_reg, fu_next;
    logic [FRAC_W-1:0]         fv_reg, fv_next;
    logic signed [IDX_W-1:0]   idx0_reg, idx0_next;
    logic                      black_reg, black_next;
    logic                      flag_reg, flag_next;
    logic [TEXEL_W-1:0]        near_reg, near_next;

    // read sequencing
    logic [2:0] cnt_reg, cnt_next;
    logic       rd_pend_reg, rd_pend_next;
    logic [1:0] rd_k_reg, rd_k_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [TEXEL_W-1:0] out_data_reg, out_data_next;
    logic               out_oob_reg, out_oob_next;

    // datapath
    logic                      in_fire;
    logic                      out_free;
    logic signed [SIZE_W:0]    w_s, h_s;
    logic signed [POS_W-1:0]   pu_prod, pv_prod;
    logic [2*SIZE_W-1:0]       area;
    logic [CELL_W-1:0]         near_x, near_y;
    logic signed [IDX_W-1:0]   yw;
    logic signed [IDX_W-1:0]   idx0_sum, idx3_sum;
    logic                      oob_hit, near_beyond;
    logic [2:0]                n_reads;
    logic [1:0]                last_k;
    logic signed [IDX_W-1:0]   rd_addr_full;
    logic                      ram_we, ram_re;
    logic [TEX_ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [TEXEL_W-1:0]        ram_rdata;
    blend_ctrl_t               bctrl;
    logic [TEXEL_W-1:0]        blend_color;

    function automatic logic signed [POS_W-1:0] in_u_scaled(
        input logic signed [COORD_W-1:0] c,
        input logic signed [SIZE_W:0]    n
    );
        logic signed [POS_W-1:0] p;
        p = c * n;
        return p;
    endfunction

    assign in_op    = s_axis_tuser;
    assign in_index = s_axis_tdata[IN_IDX_LSB +: INDEX_W];
    assign in_rgba  = s_axis_tdata[IN_RGBA_LSB +: TEXEL_W];
    assign in_u     = $signed(s_axis_tdata[IN_U_LSB +: COORD_W]);
    assign in_v     = $signed(s_axis_tdata[IN_V_LSB +: COORD_W]);

    assign w_eff = eff_size(width_reg);
    assign h_eff = eff_size(height_reg);
    assign w_s   = $signed({1'b0, w_eff});
    assign h_s   = $signed({1'b0, h_eff});

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // coordinate stage: scale by size, bilinear moves to texel centers
    assign pu_prod = in_u_scaled(u_reg, w_s);
    assign pv_prod = in_u_scaled(v_reg, h_s);
    assign area    = w_eff * h_eff;

    // nearest: truncate, clamp below at 0 and above at size-1
    always_comb
    begin
        near_x = pu_reg[POS_W-1 -: CELL_W];
        near_y = pv_reg[POS_W-1 -: CELL_W];
        if (pu_reg < 0)
        begin
            near_x = '0;
        end
        else if (near_x >= CELL_W'(w_eff))
        begin
            near_x = CELL_W'(w_eff) - CELL_W'(1);
        end
        if (pv_reg < 0)
        begin
            near_y = '0;
        end
        else if (near_y >= CELL_W'(h_eff))
        begin
            near_y = CELL_W'(h_eff) - CELL_W'(1);
        end
    end

    // flat index; (x,y) is the lowest of the four, (x+1,y+1) the highest
    assign yw       = IDX_W'(y_reg * w_s);
    assign idx0_sum = IDX_W'(x_reg) + yw;
    assign idx3_sum = idx0_sum + $signed(IDX_W'(w_eff)) + IDX_W'(1);
    assign oob_hit  = bil_reg &&
                      (idx0_sum < 0 || 32'(idx3_sum) >= 32'(limit_reg));
    assign near_beyond = !bil_reg && (32'(idx0_sum) >= 32'(MAX_TEXELS));

    // read order: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
    assign n_reads      = bil_reg ? 3'd4 : 3'd1;
    assign last_k       = bil_reg ? 2'd3 : 2'd0;
    assign rd_addr_full = idx0_reg + (cnt_reg[1] ? $signed(IDX_W'(w_eff)) : IDX_W'(0))
                          + IDX_W'(cnt_reg[0]);
    assign ram_re       = (state_reg == S_READ) && (cnt_reg < n_reads);
    assign ram_raddr    = rd_addr_full[TEX_ADDR_W-1:0];

    // texel writes go straight to the store from the input transaction
    assign ram_we    = in_fire && (in_op == OP_WRITE) &&
                       (32'(in_index) < 32'(MAX_TEXELS));
    assign ram_waddr = TEX_ADDR_W'(in_index);

    assign bctrl.tex_en   = rd_pend_reg && bil_reg;
    assign bctrl.tex_sel  = rd_k_reg;
    assign bctrl.v_first  = (state_reg == S_VMUL0);
    assign bctrl.v_second = (state_reg == S_VMUL1);

    tsn_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (MAX_TEXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_rgba),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsn_blend u_blend (
        .clk   (clk),
        .ctrl  (bctrl),
        .fu    (fu_reg),
        .fv    (fv_reg),
        .texel (ram_rdata),
        .color (blend_color)
    );

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        bil_next       = bil_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        pu_next        = pu_reg;
        pv_next        = pv_reg;
        limit_next     = limit_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        fu_next        = fu_reg;
        fv_next        = fv_reg;
        idx0_next      = idx0_reg;
        black_next     = black_reg;
        flag_next      = flag_reg;
        near_next      = near_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = ram_re;
        rd_k_next      = cnt_reg[1:0];
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_oob_next   = out_oob_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:  width_next  = cfg_wdata;
                CFG_TEX_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_op == OP_NEAREST || in_op == OP_BILINEAR))
                begin
                    bil_next   = (in_op == OP_BILINEAR);
                    u_next     = in_u;
                    v_next     = in_v;
                    state_next = S_COORD;
                end
            end
            S_COORD:
            begin
                pu_next    = pu_prod - (bil_reg ? HALF_Q16 : '0);
                pv_next    = pv_prod - (bil_reg ? HALF_Q16 : '0);
                limit_next = (32'(area) > 32'(MAX_TEXELS)) ? LIMIT_W'(MAX_TEXELS)
                                                            : LIMIT_W'(area);
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                if (bil_reg)
                begin
                    // arithmetic shift by 16 is the floor
                    x_next = pu_reg[POS_W-1 -: CELL_W];
                    y_next = pv_reg[POS_W-1 -: CELL_W];
                end
                else
                begin
                    x_next = $signed(near_x);
                    y_next = $signed(near_y);
                end
                fu_next    = pu_reg[FRAC_W-1:0];
                fv_next    = pv_reg[FRAC_W-1:0];
                state_next = S_BASE;
            end
            S_BASE:
            begin
                idx0_next  = idx0_sum;
                flag_next  = oob_hit;
                black_next = oob_hit || near_beyond;
                cnt_next   = '0;
                state_next = (oob_hit || near_beyond) ? S_DONE : S_READ;
            end
            S_READ:
            begin
                if (ram_re)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
                if (rd_pend_reg && !bil_reg)
                begin
                    near_next = ram_rdata;
                end
                if (rd_pend_reg && rd_k_reg == last_k)
                begin
                    state_next = bil_reg ? S_VMUL0 : S_DONE;
                end
            end
            S_VMUL0:
            begin
                state_next = S_VMUL1;
            end
            S_VMUL1:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_oob_next   = flag_reg;
                    if (black_reg)
                    begin
                        out_data_next = '0;
                    end
                    else if (bil_reg)
                    begin
                        out_data_next = blend_color;
                    end
                    else
                    begin
                        out_data_next = near_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= MAX_SIZE;
            height_reg    <= MAX_SIZE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bil_reg      <= bil_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        pu_reg       <= pu_next;
        pv_reg       <= pv_next;
        limit_reg    <= limit_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        fu_reg       <= fu_next;
        fv_reg       <= fv_next;
        idx0_reg     <= idx0_next;
        black_reg    <= black_next;
        flag_reg     <= flag_next;
        near_reg     <= near_next;
        rd_k_reg     <= rd_k_next;
        out_data_reg <= out_data_next;
        out_oob_reg  <= out_oob_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_oob_reg;

    // store is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("texel store written and read in the same cycle");

    // read data handled by the sequencer is tracked in the cycle after a read issue
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> rd_pend_reg)
        else $error("texel read data not tracked one cycle after issue");

    // a new result only comes out of the final state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded outside the final state");

    // a flagged result is black
    a_oob_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_oob_reg) |-> out_data_reg == '0)
        else $error("out-of-bounds result is not black");

    // reads are only issued for an in-range sample
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!black_reg && idx0_reg >= 0))
        else $error("texel read issued for an out-of-range sample");

endmodule
